// ----- rtl/sensor_packet_deframer_top_assert.svh -----
// assertion macros for the sensor packet deframer checker
`ifndef SENSOR_PACKET_DEFRAMER_TOP_ASSERT_SVH
`define SENSOR_PACKET_DEFRAMER_TOP_ASSERT_SVH

// condition in a cycle implies a consequence in the same cycle
`define SPD_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
    else $error("spd assertion failed");

// condition in a cycle implies a consequence in the next cycle
`define SPD_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
    else $error("spd assertion failed");

`endif

// ----- rtl/spd_pkg.sv -----
// shared types and constants of the sensor packet deframer
`default_nettype none

package spd_pkg;

  localparam int unsigned MaxTypes = 8;
  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned CfgDataW = 64;

  localparam logic [CfgIdxW-1:0] CFG_START_BYTES   = 2'd0;
  localparam logic [CfgIdxW-1:0] CFG_FRAME_LENGTHS = 2'd1;
  localparam logic [CfgIdxW-1:0] CFG_ENABLES       = 2'd2;
  localparam logic [CfgIdxW-1:0] CFG_LOW_FIRST     = 2'd3;

  localparam logic [1:0] STATUS_IN_FRAME = 2'd0;
  localparam logic [1:0] STATUS_GOOD     = 2'd1;
  localparam logic [1:0] STATUS_BAD      = 2'd2;
  localparam logic [1:0] STATUS_SKIPPED  = 2'd3;

  localparam logic [7:0] MinFrameLen = 8'd3;

  typedef enum logic [2:0] {
    KIND_SKIP,
    KIND_START,
    KIND_BODY,
    KIND_CHK1,
    KIND_CHK2
  } spd_kind_e;

  typedef struct packed {
    spd_kind_e  kind;
    logic [7:0] data;
    logic [7:0] pos;
    logic [2:0] tidx;
  } spd_item_t;

endpackage

`default_nettype wire

// ----- rtl/spd_front.sv -----
// front end: start byte match, frame tracking and byte classification
`default_nettype none

module spd_front #(
  parameter int unsigned NUM_TYPES = 8
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             accept_i,
  input  wire logic [7:0]       rx_byte_i,
  input  wire logic [63:0]      start_bytes_i,
  input  wire logic [63:0]      frame_lengths_i,
  input  wire logic [7:0]       enables_i,
  output spd_pkg::spd_item_t    item_o
);
  import spd_pkg::*;

  logic       in_frame_q, in_frame_d;
  logic [7:0] seen_q, seen_d;
  logic [7:0] len_q, len_d;
  logic [2:0] type_q, type_d;

  logic       hit;
  logic [2:0] hit_idx;
  logic [7:0] hit_len;
  logic [8:0] pos_plus2;

  always_comb begin
    hit     = 1'b0;
    hit_idx = '0;
    hit_len = '0;
    for (int k = NUM_TYPES - 1; k >= 0; k--) begin
      if (enables_i[k] && (frame_lengths_i[8*k +: 8] >= MinFrameLen) &&
          (start_bytes_i[8*k +: 8] == rx_byte_i)) begin
        hit     = 1'b1;
        hit_idx = 3'(k);
        hit_len = frame_lengths_i[8*k +: 8];
      end
    end
  end

  assign pos_plus2 = {1'b0, seen_q} + 9'd2;

  always_comb begin
    in_frame_d   = in_frame_q;
    seen_d       = seen_q;
    len_d        = len_q;
    type_d       = type_q;
    item_o.data  = rx_byte_i;
    item_o.pos   = '0;
    item_o.tidx  = '0;
    item_o.kind  = KIND_SKIP;
    if (!in_frame_q) begin
      if (hit) begin
        item_o.kind = KIND_START;
        item_o.tidx = hit_idx;
        in_frame_d  = 1'b1;
        seen_d      = 8'd1;
        len_d       = hit_len;
        type_d      = hit_idx;
      end
    end else begin
      item_o.pos  = seen_q;
      item_o.tidx = type_q;
      seen_d      = seen_q + 8'd1;
      if (pos_plus2 < {1'b0, len_q}) begin
        item_o.kind = KIND_BODY;
      end else if (pos_plus2 == {1'b0, len_q}) begin
        item_o.kind = KIND_CHK1;
      end else begin
        item_o.kind = KIND_CHK2;
        in_frame_d  = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_frame_q <= 1'b0;
      seen_q     <= '0;
      len_q      <= '0;
      type_q     <= '0;
    end else if (accept_i) begin
      in_frame_q <= in_frame_d;
      seen_q     <= seen_d;
      len_q      <= len_d;
      type_q     <= type_d;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/spd_queue.sv -----
// two entry queue between front and back
`default_nettype none

module spd_queue (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               wr_i,
  input  wire spd_pkg::spd_item_t wr_item_i,
  output logic                    full_o,
  input  wire logic               rd_i,
  output spd_pkg::spd_item_t      rd_item_o,
  output logic                    empty_o
);
  import spd_pkg::*;

  spd_item_t  entries_q [2];
  logic       wr_ptr_q, rd_ptr_q;
  logic [1:0] count_q;

  assign full_o    = (count_q == 2'd2);
  assign empty_o   = (count_q == 2'd0);
  assign rd_item_o = entries_q[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= '0;
    end else begin
      if (wr_i) begin
        wr_ptr_q <= ~wr_ptr_q;
      end
      if (rd_i) begin
        rd_ptr_q <= ~rd_ptr_q;
      end
      count_q <= count_q + {1'b0, wr_i} - {1'b0, rd_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_i) begin
      entries_q[wr_ptr_q] <= wr_item_i;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/spd_back.sv -----
// back end: checksum accumulation, status and result register
`default_nettype none

module spd_back (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire spd_pkg::spd_item_t item_i,
  input  wire logic               item_valid_i,
  output logic                    take_o,
  input  wire logic               low_first_i,
  input  wire logic               pop_i,
  output logic                    empty_o,
  output logic [7:0]              data_byte_o,
  output logic [7:0]              frame_position_o,
  output logic [2:0]              type_index_o,
  output logic                    frame_last_o,
  output logic [1:0]              status_o
);
  import spd_pkg::*;

  logic        out_valid_q;
  logic [15:0] sum_q, sum_d;
  logic [7:0]  first_q, first_d;
  logic [15:0] sent;
  logic [1:0]  status_d;

  assign take_o  = item_valid_i && (!out_valid_q || pop_i);
  assign empty_o = !out_valid_q;
  assign sent    = low_first_i ? {item_i.data, first_q} : {first_q, item_i.data};

  always_comb begin
    sum_d    = sum_q;
    first_d  = first_q;
    status_d = STATUS_IN_FRAME;
    case (item_i.kind)
      KIND_SKIP:  status_d = STATUS_SKIPPED;
      KIND_START: sum_d = {8'd0, item_i.data};
      KIND_BODY:  sum_d = sum_q + {8'd0, item_i.data};
      KIND_CHK1:  first_d = item_i.data;
      KIND_CHK2:  status_d = (sent == sum_q) ? STATUS_GOOD : STATUS_BAD;
      default:    status_d = STATUS_IN_FRAME;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (take_o) begin
      out_valid_q <= 1'b1;
    end else if (pop_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take_o) begin
      sum_q            <= sum_d;
      first_q          <= first_d;
      data_byte_o      <= item_i.data;
      frame_position_o <= item_i.pos;
      type_index_o     <= item_i.tidx;
      frame_last_o     <= (item_i.kind == KIND_CHK2);
      status_o         <= status_d;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/sensor_packet_deframer_top.sv -----
// top level of the sensor packet deframer
// usage:
//   input queue: drive rx_byte_i and push; a beat moves when push is high and
//   full is low. one received byte per beat.
//   result queue: while empty is low the oldest result is on the result ports;
//   it moves when pop is high. every input byte gives exactly one result.
//   configuration: cfg_we_i writes cfg_data_i into register cfg_idx_i (0 start
//   bytes, 1 frame lengths, 2 enables, 3 checksum low first); the user writes
//   it only while no byte is in flight, which the block itself does not enforce.
//   path: an accepted byte is written into the two entry queue and moves on
//   into the result register when the result stage is empty or being popped.
//   throughput: one byte per cycle unless a low pop stalls it, set by the table
//   match in the front end and the single 16 bit add in the back end.
//   reset: frame tracking returns to hunting, queue and result stage empty,
//   configuration registers zero.
//   stall: when pop stays low the result holds, the two entry queue fills and
//   full rises; nothing is dropped.
`default_nettype none

module sensor_packet_deframer_top #(
  parameter int unsigned NUM_TYPES = 8
) (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         cfg_we_i,
  input  wire logic [1:0]   cfg_idx_i,
  input  wire logic [63:0]  cfg_data_i,
  input  wire logic         push,
  output logic              full,
  input  wire logic [7:0]   rx_byte_i,
  output logic              empty,
  input  wire logic         pop,
  output logic [7:0]        data_byte_o,
  output logic [7:0]        frame_position_o,
  output logic [2:0]        type_index_o,
  output logic              frame_last_o,
  output logic [1:0]        status_o
);
  import spd_pkg::*;

  logic [63:0] start_bytes_q;
  logic [63:0] frame_lengths_q;
  logic [7:0]  enables_q;
  logic        low_first_q;
  logic [7:0]  enables_used;

  logic      accept;
  spd_item_t front_item;
  spd_item_t queue_item;
  logic      queue_empty;
  logic      take;

  for (genvar g = 0; g < MaxTypes; g++) begin : g_en
    assign enables_used[g] = (g < NUM_TYPES) ? enables_q[g] : 1'b0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_bytes_q   <= '0;
      frame_lengths_q <= '0;
      enables_q       <= '0;
      low_first_q     <= 1'b0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_START_BYTES:   start_bytes_q   <= cfg_data_i;
        CFG_FRAME_LENGTHS: frame_lengths_q <= cfg_data_i;
        CFG_ENABLES:       enables_q       <= cfg_data_i[7:0];
        CFG_LOW_FIRST:     low_first_q     <= cfg_data_i[0];
        default:           low_first_q     <= low_first_q;
      endcase
    end
  end

  assign accept = push && !full;

  spd_front #(
    .NUM_TYPES(NUM_TYPES)
  ) u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .accept_i       (accept),
    .rx_byte_i      (rx_byte_i),
    .start_bytes_i  (start_bytes_q),
    .frame_lengths_i(frame_lengths_q),
    .enables_i      (enables_used),
    .item_o         (front_item)
  );

  spd_queue u_queue (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .wr_i     (accept),
    .wr_item_i(front_item),
    .full_o   (full),
    .rd_i     (take),
    .rd_item_o(queue_item),
    .empty_o  (queue_empty)
  );

  spd_back u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .item_i          (queue_item),
    .item_valid_i    (!queue_empty),
    .take_o          (take),
    .low_first_i     (low_first_q),
    .pop_i           (pop),
    .empty_o         (empty),
    .data_byte_o     (data_byte_o),
    .frame_position_o(frame_position_o),
    .type_index_o    (type_index_o),
    .frame_last_o    (frame_last_o),
    .status_o        (status_o)
  );

endmodule

`default_nettype wire

// ----- rtl/spd_checker.sv -----
// port level checker for the sensor packet deframer and its bind
`default_nettype none
`include "sensor_packet_deframer_top_assert.svh"

module spd_checker (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        empty,
  input wire logic        pop,
  input wire logic [7:0]  data_byte_o,
  input wire logic [7:0]  frame_position_o,
  input wire logic [2:0]  type_index_o,
  input wire logic        frame_last_o,
  input wire logic [1:0]  status_o
);
  import spd_pkg::*;

  `SPD_ASSERT_NXT(a_hold_on_stall, clk_i, rst_ni, !empty && !pop,
    !empty && $stable(data_byte_o) && $stable(status_o) && $stable(frame_position_o))
  `SPD_ASSERT_IMP(a_last_has_verdict, clk_i, rst_ni, !empty && frame_last_o,
    status_o == STATUS_GOOD || status_o == STATUS_BAD)
  `SPD_ASSERT_IMP(a_verdict_only_last, clk_i, rst_ni,
    !empty && (status_o == STATUS_GOOD || status_o == STATUS_BAD), frame_last_o)
  `SPD_ASSERT_IMP(a_skip_fields_zero, clk_i, rst_ni, !empty && status_o == STATUS_SKIPPED,
    frame_position_o == 8'd0 && type_index_o == 3'd0 && !frame_last_o)

endmodule

bind sensor_packet_deframer_top spd_checker u_spd_checker (.*);

`default_nettype wire

// ----- verif/sensor_packet_deframer_top_test.sv -----
// self-checking testbench for sensor_packet_deframer_top with directed and random byte streams
`timescale 1ns / 100ps

module sensor_packet_deframer_top_test;
  import spd_pkg::*;

  localparam int StallLimit = 5000;
  localparam int PhaseBytes = 200;
  localparam int NumPhases = 9;

  typedef struct packed {
    logic [7:0] data;
    logic [7:0] pos;
    logic [2:0] tidx;
    logic       last;
    logic [1:0] status;
  } deframe_result_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_we_i = 1'b0;
  logic [1:0]  cfg_idx_i = CFG_START_BYTES;
  logic [63:0] cfg_data_i = '0;
  logic        push = 1'b0;
  logic        full;
  logic [7:0]  rx_byte_i = '0;
  logic        empty;
  logic        pop = 1'b0;
  logic [7:0]  data_byte_o;
  logic [7:0]  frame_position_o;
  logic [2:0]  type_index_o;
  logic        frame_last_o;
  logic [1:0]  status_o;

  sensor_packet_deframer_top u_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_idx_i       (cfg_idx_i),
    .cfg_data_i      (cfg_data_i),
    .push            (push),
    .full            (full),
    .rx_byte_i       (rx_byte_i),
    .empty           (empty),
    .pop             (pop),
    .data_byte_o     (data_byte_o),
    .frame_position_o(frame_position_o),
    .type_index_o    (type_index_o),
    .frame_last_o    (frame_last_o),
    .status_o        (status_o)
  );

  // shadow registers
  logic [63:0] cfg_starts = '0;
  logic [63:0] cfg_lengths = '0;
  logic [7:0]  cfg_enables = '0;
  logic        cfg_low_first = 1'b0;

  // frame tracking of the predictor
  logic        frame_open = 1'b0;
  logic [7:0]  byte_count = '0;
  logic [7:0]  open_length = '0;
  logic [2:0]  open_type = '0;
  logic [15:0] body_sum = '0;
  logic [7:0]  held_check = '0;

  logic [7:0]      rx_backlog[$];
  deframe_result_t expected_beats[$];

  int  send_idle_pct = 0;
  int  recv_idle_pct = 0;
  logic took_byte = 1'b0;
  int  stall_cycles = 0;
  int  error_count = 0;
  int  bytes_in = 0;
  int  frames_good = 0;
  int  frames_bad = 0;
  int  bytes_skipped = 0;
  int  table_loads = 0;

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  function automatic logic entry_live(input int k);
    return cfg_enables[k] && (cfg_lengths[8*k +: 8] >= MinFrameLen);
  endfunction

  function automatic deframe_result_t predict_deframe(input logic [7:0] b);
    deframe_result_t r;
    int hit;
    logic [15:0] sent;
    hit = -1;
    r.data = b;
    r.pos = '0;
    r.tidx = '0;
    r.last = 1'b0;
    r.status = STATUS_IN_FRAME;
    if (!frame_open) begin
      for (int k = MaxTypes - 1; k >= 0; k--) begin
        if (entry_live(k) && cfg_starts[8*k +: 8] == b) hit = k;
      end
      if (hit < 0) begin
        r.status = STATUS_SKIPPED;
      end else begin
        open_type = 3'(hit);
        open_length = cfg_lengths[8*hit +: 8];
        frame_open = 1'b1;
        byte_count = 8'd1;
        body_sum = {8'h00, b};
        r.tidx = open_type;
      end
    end else begin
      r.pos = byte_count;
      r.tidx = open_type;
      if ({1'b0, byte_count} + 9'd2 < {1'b0, open_length}) begin
        body_sum = body_sum + {8'h00, b};
      end else if ({1'b0, byte_count} + 9'd2 == {1'b0, open_length}) begin
        held_check = b;
      end else begin
        sent = cfg_low_first ? {b, held_check} : {held_check, b};
        r.last = 1'b1;
        r.status = (sent == body_sum) ? STATUS_GOOD : STATUS_BAD;
        frame_open = 1'b0;
      end
      byte_count = byte_count + 8'd1;
    end
    return r;
  endfunction

  function automatic logic [7:0] random_byte();
    case ($urandom_range(9))
      0: return 8'h00;
      1: return 8'hFF;
      default: return 8'($urandom_range(255));
    endcase
  endfunction

  // queues one frame of entry k, cut after keep bytes when keep is positive and below the frame length
  function automatic int queue_frame(input int k, input logic corrupt, input int keep);
    logic [7:0]  sb;
    logic [7:0]  bd;
    logic [15:0] sum;
    int len;
    int n;
    sb = cfg_starts[8*k +: 8];
    len = int'(cfg_lengths[8*k +: 8]);
    n = (keep > 0 && keep < len) ? keep : len;
    sum = {8'h00, sb};
    rx_backlog.push_back(sb);
    for (int i = 1; i < len - 2; i++) begin
      bd = random_byte();
      sum = sum + {8'h00, bd};
      if (i < n) rx_backlog.push_back(bd);
    end
    if (corrupt) sum = sum ^ (16'd1 << $urandom_range(15));
    if (len - 2 < n) rx_backlog.push_back(cfg_low_first ? sum[7:0] : sum[15:8]);
    if (len - 1 < n) rx_backlog.push_back(cfg_low_first ? sum[15:8] : sum[7:0]);
    return n;
  endfunction

  task automatic set_reg(input logic [1:0] idx, input logic [63:0] value);
    @(negedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= value;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      CFG_START_BYTES:   cfg_starts = value;
      CFG_FRAME_LENGTHS: cfg_lengths = value;
      CFG_ENABLES:       cfg_enables = value[7:0];
      CFG_LOW_FIRST:     cfg_low_first = value[0];
      default: ;
    endcase
  endtask

  task automatic load_table(input logic [63:0] starts, input logic [63:0] lengths,
                            input logic [63:0] enables, input logic [63:0] low_first);
    set_reg(CFG_START_BYTES, starts);
    set_reg(CFG_FRAME_LENGTHS, lengths);
    set_reg(CFG_ENABLES, enables);
    set_reg(CFG_LOW_FIRST, low_first);
    table_loads++;
  endtask

  task automatic wait_idle();
    while (rx_backlog.size() != 0 || expected_beats.size() != 0) @(posedge clk_i);
  endtask

  // input driver
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      push <= 1'b0;
      pop <= 1'b0;
    end else begin
      if (!(push && !took_byte)) begin
        if (rx_backlog.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          push <= 1'b1;
          rx_byte_i <= rx_backlog[0];
        end else begin
          push <= 1'b0;
        end
      end
      pop <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // accept, predict, check and watchdog
  always @(posedge clk_i) begin
    deframe_result_t want;
    logic moved;
    moved = 1'b0;
    if (!rst_ni) begin
      took_byte <= 1'b0;
    end else begin
      took_byte <= push && !full;
      if (push && !full) begin
        expected_beats.push_back(predict_deframe(rx_byte_i));
        void'(rx_backlog.pop_front());
        bytes_in++;
        moved = 1'b1;
      end
      if (pop && !empty) begin
        moved = 1'b1;
        if (expected_beats.size() == 0) begin
          $error("result beat with no byte outstanding: data_byte %0h", data_byte_o);
          error_count++;
        end else begin
          want = expected_beats.pop_front();
          if (data_byte_o !== want.data) begin
            $error("data_byte expected %0h got %0h", want.data, data_byte_o);
            error_count++;
          end
          if (frame_position_o !== want.pos) begin
            $error("frame_position expected %0d got %0d", want.pos, frame_position_o);
            error_count++;
          end
          if (type_index_o !== want.tidx) begin
            $error("type_index expected %0d got %0d", want.tidx, type_index_o);
            error_count++;
          end
          if (frame_last_o !== want.last) begin
            $error("frame_last expected %0b got %0b", want.last, frame_last_o);
            error_count++;
          end
          if (status_o !== want.status) begin
            $error("status expected %0d got %0d", want.status, status_o);
            error_count++;
          end
          if (want.status == STATUS_GOOD) frames_good++;
          if (want.status == STATUS_BAD) frames_bad++;
          if (want.status == STATUS_SKIPPED) bytes_skipped++;
        end
      end
      stall_cycles = moved ? 0 : stall_cycles + 1;
      if (stall_cycles >= StallLimit) begin
        $display("sensor_packet_deframer_top verification failed");
        $finish;
      end
    end
  end

  initial begin
    logic [63:0] t_starts;
    logic [63:0] t_lengths;
    logic [63:0] t_en;
    logic [63:0] t_low;
    logic [7:0]  sb;
    logic        shadowed;
    int reach[$];
    int added;
    int pick;
    int k;
    int r;

    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    send_idle_pct = 11;
    recv_idle_pct = 64;

    // short entry, duplicate start bytes, disabled entry, zero length entry
    load_table(64'h2211_FF44_005A_5A5A, 64'h0006_0403_0405_0302,
               64'hFFFF_FFFF_FFFF_FFEF, 64'hFFFF_FFFF_FFFF_FFFE);
    rx_backlog.push_back(8'h33);
    rx_backlog.push_back(8'h44);
    rx_backlog.push_back(8'h22);
    void'(queue_frame(1, 1'b0, 0));
    void'(queue_frame(3, 1'b1, 0));
    void'(queue_frame(5, 1'b0, 0));
    void'(queue_frame(6, 1'b0, 3));
    wait_idle();
    // table changes while a frame is open
    load_table(64'h2211_FF44_005A_5A5A, 64'h0004_0403_0405_0302, 64'h0000_0000_0000_00EF,
               64'h1);
    for (int i = 0; i < 3; i++) rx_backlog.push_back(random_byte());
    void'(queue_frame(6, 1'b0, 0));
    wait_idle();

    for (int p = 0; p < NumPhases; p++) begin
      if (p == NumPhases / 3) begin
        send_idle_pct = 64;
        recv_idle_pct = 11;
      end else if (p == 2 * NumPhases / 3) begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      case (p)
        0: begin
          t_starts = '0;
          t_lengths = {8{8'd3}};
          t_en = '1;
          t_low = '1;
        end
        3: begin
          t_starts = '1;
          t_lengths = '1;
          t_en = 64'hFF;
          t_low = '0;
        end
        6: begin
          t_starts = {$urandom, $urandom};
          t_lengths = {$urandom, $urandom};
          t_en = '0;
          t_low = {$urandom, $urandom};
        end
        default: begin
          for (int j = 0; j < MaxTypes; j++) begin
            sb = random_byte();
            if (j > 0 && $urandom_range(4) == 0) sb = t_starts[8*(j-1) +: 8];
            t_starts[8*j +: 8] = sb;
            r = $urandom_range(99);
            if (r < 15) t_lengths[8*j +: 8] = 8'($urandom_range(2));
            else if (r < 30) t_lengths[8*j +: 8] = 8'd3;
            else if (r < 35) t_lengths[8*j +: 8] = 8'($urandom_range(90, 40));
            else t_lengths[8*j +: 8] = 8'($urandom_range(16, 4));
          end
          t_en = {$urandom, $urandom};
          t_en[7:0] = 8'($urandom_range(255, 1));
          t_low = {$urandom, $urandom};
        end
      endcase
      load_table(t_starts, t_lengths, t_en, t_low);

      // entries that a start byte can actually reach
      reach.delete();
      for (int j = 0; j < MaxTypes; j++) begin
        shadowed = 1'b0;
        for (int i = 0; i < j; i++) begin
          if (entry_live(i) && cfg_starts[8*i +: 8] == cfg_starts[8*j +: 8]) shadowed = 1'b1;
        end
        if (entry_live(j) && !shadowed) reach.push_back(j);
      end

      added = 0;
      while (added < PhaseBytes) begin
        pick = $urandom_range(99);
        if (reach.size() == 0 || pick < 15) begin
          rx_backlog.push_back(random_byte());
          added++;
        end else begin
          k = reach[$urandom_range(reach.size() - 1)];
          if (pick < 25) begin
            added += queue_frame(k, 1'b0,
                                 $urandom_range(int'(cfg_lengths[8*k +: 8]) - 1, 1));
          end else begin
            added += queue_frame(k, $urandom_range(99) < 15, 0);
          end
        end
      end
      wait_idle();
    end

    repeat (4) @(posedge clk_i);
    if (expected_beats.size() != 0) begin
      $error("%0d result beats never arrived", expected_beats.size());
      error_count++;
    end
    $display("run covered %0d bytes under %0d table settings", bytes_in, table_loads);
    $display("frames good %0d, frames bad %0d, bytes skipped while hunting %0d",
             frames_good, frames_bad, bytes_skipped);
    if (error_count == 0) begin
      $display("sensor_packet_deframer_top verification clean");
    end else begin
      $display("sensor_packet_deframer_top verification failed");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
+incdir+rtl
rtl/spd_pkg.sv
rtl/spd_front.sv
rtl/spd_queue.sv
rtl/spd_back.sv
rtl/sensor_packet_deframer_top.sv
rtl/spd_checker.sv
verif/sensor_packet_deframer_top_test.sv
